/* sv/bmc_pkg.sv */
// shared types, codes and helper functions of the cartridge bank mapper
// no dependencies; used by bank_mapper_cartridge, bmc_route_sb_pkg and tb

package bmc_pkg;

  // field widths
  localparam int ActionW  = 2;
  localparam int AddrW    = 16;
  localparam int ByteW    = 8;
  localparam int TargetW  = 3;
  localparam int FlashW   = 23;
  localparam int BankW    = 10;
  localparam int GenRegW  = 4;
  localparam int IdStepW  = 3;
  localparam int NumBanks = 4;

  // packed stream word widths
  localparam int InDataW  = 24;   // address, data
  localparam int OutDataW = 56;   // 52 bits of fields, padded to whole bytes

  typedef enum logic [ActionW-1:0] {
    ACT_MEM_RD = 2'd0,
    ACT_MEM_WR = 2'd1,
    ACT_IO_WR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [TargetW-1:0] {
    TGT_NONE      = 3'd0,
    TGT_FLASH_RD  = 3'd1,
    TGT_FLASH_WR  = 3'd2,
    TGT_SOUND_RD  = 3'd3,
    TGT_SOUND_WR  = 3'd4,
    TGT_REG_RD    = 3'd5,
    TGT_GEN_WR    = 3'd6,
    TGT_UNMAPPED  = 3'd7
  } target_t;

  // mapper register addresses
  localparam logic [AddrW-1:0] REG_ID     = 16'h7FFC;
  localparam logic [AddrW-1:0] REG_CONFIG = 16'h7FFD;
  localparam logic [AddrW-1:0] REG_OFFSET = 16'h7FFE;
  localparam logic [AddrW-1:0] REG_ENABLE = 16'h7FFF;

  // id sequence
  localparam logic [ByteW-1:0]   ID_UNLOCK   = 8'h9F;
  localparam logic [IdStepW-1:0] ID_LAST     = 3'd4;

  // i/o ports of the sound generator
  localparam logic [ByteW-1:0] PORT_GEN_LATCH = 8'h10;
  localparam logic [ByteW-1:0] PORT_GEN_DATA  = 8'h11;
  localparam logic [ByteW-1:0] PORT_ECHO_LATCH = 8'hA0;
  localparam logic [ByteW-1:0] PORT_ECHO_DATA  = 8'hA1;

  // sound window decode, address already mirrored
  function automatic logic in_window(input logic             four_bank,
                                     input logic             plus_mode,
                                     input logic [ByteW-1:0] raw2,
                                     input logic [ByteW-1:0] raw3,
                                     input logic [AddrW-1:0] a);
    logic hit;
    if (four_bank) begin
      hit = 1'b0;
    end else if (plus_mode) begin
      hit = raw3[7] && (a >= 16'hB800) && (a < 16'hBFFE);
    end else begin
      hit = (raw2[5:0] == 6'h3F) && (a >= 16'h9800) && (a < 16'hA000);
    end
    return hit;
  endfunction

  // id reply byte for each step of the sequence
  function automatic logic [ByteW-1:0] id_reply(input logic [IdStepW-1:0] step);
    logic [ByteW-1:0] v;
    case (step)
      3'd1:    v = 8'h1F;
      3'd2:    v = 8'h23;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h00;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

endpackage

/* sv/bank_mapper_cartridge.sv */
// cartridge bank mapper: cpu bus decoder with four switchable 8 kB banks
// depends on bmc_pkg
//
// usage:
//   in_*  : one cpu access per word. in_tuser = action (0 mem read,
//           1 mem write, 2 i/o write), in_tdata = address and data byte.
//   out_* : one routing word per accepted input word. out_tuser = target,
//           out_tdata = flash address, read value, sound offset, plus mode,
//           generator register and write value.
//   path: an accepted word is registered in the input register, then decoded
//           into the output register, which drives out_*.
//   throughput: one word per cycle while out_tready is high; all decode and
//           the bank, mode and id register updates are done combinationally
//           between the input register and the output register.
//   reset: rst_n low clears both stages and loads banks 0..3, all other
//           mapper registers zero.
//   stall: while out_tready is low the output word holds, the input
//           register fills and in_tready then drops; nothing is lost.

module bank_mapper_cartridge (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bmc_pkg::InDataW-1:0]   in_tdata,   // address[15:0], data[23:16]
  input  logic [bmc_pkg::ActionW-1:0]   in_tuser,   // action[1:0]
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // flash_addr[22:0], read_data[30:23], sound_offset[38:31],
  // sound_plus_mode[39], gen_reg[43:40], write_value[51:44], zero[55:52]
  output logic [bmc_pkg::OutDataW-1:0]  out_tdata,
  output logic [bmc_pkg::TargetW-1:0]   out_tuser   // target[2:0]
);

  // ---------------------------------------------------------------- input register
  logic                        s1_valid_r;
  bmc_pkg::action_t            act_r;
  logic [bmc_pkg::AddrW-1:0]   addr_r;
  logic [bmc_pkg::ByteW-1:0]   data_r;

  logic out_tvalid_r;
  logic out_free;     // output register can take a word this cycle
  logic s1_adv;       // input register moves into the output register

  assign out_free  = !out_tvalid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= bmc_pkg::action_t'(in_tuser);
      addr_r <= in_tdata[15:0];
      data_r <= in_tdata[23:16];
    end
  end

  // ---------------------------------------------------------------- mapper state
  logic [bmc_pkg::BankW-1:0]   bank_adj_r [bmc_pkg::NumBanks];
  logic [bmc_pkg::BankW-1:0]   bank_adj_nxt [bmc_pkg::NumBanks];
  logic [bmc_pkg::ByteW-1:0]   bank_raw_r [bmc_pkg::NumBanks];
  logic [bmc_pkg::ByteW-1:0]   bank_raw_nxt [bmc_pkg::NumBanks];
  logic [bmc_pkg::ByteW-1:0]   enable_r, enable_nxt;
  logic [bmc_pkg::ByteW-1:0]   offset_r, offset_nxt;
  logic [bmc_pkg::ByteW-1:0]   mode_r, mode_nxt;
  logic [bmc_pkg::IdStepW-1:0] id_step_r, id_step_nxt;
  logic                        plus_r, plus_nxt;          // sound mode bit 5
  logic [bmc_pkg::GenRegW-1:0] gen_latch_r, gen_latch_nxt;

  // ---------------------------------------------------------------- decode
  logic [bmc_pkg::AddrW-1:0]   fa_addr;     // mirrored into 0x4000..0xBFFF
  logic [1:0]                  page;
  logic                        reg_area;
  logic [bmc_pkg::ByteW-1:0]   port;
  logic                        port_hit;

  // flip bit 15 when the address lies below 0x4000 or at 0xC000 and up
  assign fa_addr  = {addr_r[15] ^ (addr_r[15] ~^ addr_r[14]), addr_r[14:0]};
  // (a >> 13) - 2, modulo four
  assign page     = {~fa_addr[14], fa_addr[13]};
  assign reg_area = (addr_r[15:2] == bmc_pkg::REG_ID[15:2]);
  assign port     = addr_r[7:0];
  assign port_hit = (port == bmc_pkg::PORT_GEN_LATCH) || (port == bmc_pkg::PORT_GEN_DATA) ||
                    (((port == bmc_pkg::PORT_ECHO_LATCH) || (port == bmc_pkg::PORT_ECHO_DATA))
                     && mode_r[1]);

  bmc_pkg::target_t            tgt;
  logic [bmc_pkg::FlashW-1:0]  fa;
  logic [bmc_pkg::ByteW-1:0]   rd;
  logic [bmc_pkg::ByteW-1:0]   so;
  logic [bmc_pkg::GenRegW-1:0] gr;
  logic [bmc_pkg::ByteW-1:0]   wv;
  logic [bmc_pkg::FlashW-1:0]  flash_of;

  assign flash_of = {bank_adj_r[page], fa_addr[12:0]};

  always_comb begin
    bank_adj_nxt  = bank_adj_r;
    bank_raw_nxt  = bank_raw_r;
    enable_nxt    = enable_r;
    offset_nxt    = offset_r;
    mode_nxt      = mode_r;
    id_step_nxt   = id_step_r;
    plus_nxt      = plus_r;
    gen_latch_nxt = gen_latch_r;
    tgt = bmc_pkg::TGT_NONE;
    fa  = '0;
    rd  = '0;
    so  = '0;
    gr  = '0;
    wv  = '0;

    unique case (act_r)
      bmc_pkg::ACT_MEM_RD: begin
        if (reg_area && enable_r[0]) begin
          tgt = bmc_pkg::TGT_REG_RD;
          if (addr_r == bmc_pkg::REG_ID) begin
            rd = mode_r[6] ? bmc_pkg::id_reply(id_step_r) : 8'hFF;
          end else if (addr_r == bmc_pkg::REG_CONFIG) begin
            rd = mode_r | 8'h80;     // bit 7 reads as ready
          end else if (addr_r == bmc_pkg::REG_OFFSET) begin
            rd = offset_r;
          end else begin
            rd = enable_r;
          end
        end else if (bmc_pkg::in_window(mode_r[3], plus_r, bank_raw_r[2], bank_raw_r[3],
                                        fa_addr)) begin
          tgt = bmc_pkg::TGT_SOUND_RD;
          so  = fa_addr[7:0];
        end else if (!mode_r[2]) begin
          tgt = bmc_pkg::TGT_FLASH_RD;
          fa  = flash_of;
        end else begin
          tgt = bmc_pkg::TGT_UNMAPPED;
          rd  = 8'hFF;
        end
      end

      bmc_pkg::ACT_MEM_WR: begin
        // register writes first; the routing below sees the new values
        if (addr_r == bmc_pkg::REG_ENABLE) begin
          enable_nxt = data_r;
        end else if (reg_area && enable_r[0]) begin
          if (addr_r == bmc_pkg::REG_ID) begin
            if (mode_r[6]) begin
              if (id_step_r == '0) begin
                if (data_r == bmc_pkg::ID_UNLOCK) id_step_nxt = 3'd1;
              end else if (id_step_r < bmc_pkg::ID_LAST) begin
                id_step_nxt = id_step_r + 3'd1;
              end else begin
                id_step_nxt = '0;
              end
            end
          end else if (addr_r == bmc_pkg::REG_CONFIG) begin
            mode_nxt = data_r;
          end else begin
            offset_nxt = data_r;
          end
        end

        if (enable_nxt[4]) begin
          // flash write mode
          if (!mode_nxt[2]) begin
            tgt = bmc_pkg::TGT_FLASH_WR;
            fa  = flash_of;
            wv  = data_r;
          end
        end else if (mode_nxt[3]) begin
          // four-bank scheme: with mode bit 0 clear, a write at 0x6000 and up switches its bank
          if (!mode_nxt[0] && (fa_addr[15:13] >= 3'd3)) begin
            bank_raw_nxt[page] = data_r;
            bank_adj_nxt[page] = {2'b00, data_r} + {offset_nxt, mode_nxt[5:4]};
          end
        end else begin
          // sound-chip scheme
          if (bmc_pkg::in_window(mode_nxt[3], plus_r, bank_raw_r[2], bank_raw_r[3],
                                 fa_addr)) begin
            tgt = bmc_pkg::TGT_SOUND_WR;
            so  = fa_addr[7:0];
            wv  = data_r;
          end
          if ((fa_addr[12:11] == 2'b10) && !mode_nxt[0]) begin
            bank_raw_nxt[page] = data_r;
            bank_adj_nxt[page] = {2'b00, data_r} + {offset_nxt, mode_nxt[5:4]};
          end
          if (fa_addr[15:1] == 15'h5FFF) begin
            plus_nxt = data_r[5];
          end
        end
      end

      bmc_pkg::ACT_IO_WR: begin
        if (port_hit) begin
          if (port[0]) begin
            tgt = bmc_pkg::TGT_GEN_WR;
            gr  = gen_latch_r;
            wv  = data_r;
          end else begin
            gen_latch_nxt = data_r[3:0];
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bmc_pkg::NumBanks; i++) begin
        bank_adj_r[i] <= bmc_pkg::BankW'(i);
        bank_raw_r[i] <= bmc_pkg::ByteW'(i);
      end
      enable_r    <= '0;
      offset_r    <= '0;
      mode_r      <= '0;
      id_step_r   <= '0;
      plus_r      <= 1'b0;
      gen_latch_r <= '0;
    end else if (s1_adv) begin
      bank_adj_r  <= bank_adj_nxt;
      bank_raw_r  <= bank_raw_nxt;
      enable_r    <= enable_nxt;
      offset_r    <= offset_nxt;
      mode_r      <= mode_nxt;
      id_step_r   <= id_step_nxt;
      plus_r      <= plus_nxt;
      gen_latch_r <= gen_latch_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [bmc_pkg::OutDataW-1:0] out_tdata_r;
  logic [bmc_pkg::TargetW-1:0]  out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_free) begin
      out_tvalid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tuser_r <= tgt;
      out_tdata_r <= {4'b0000, wv, gr, plus_nxt, so, rd, fa};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------- checks
  // the id sequence never runs past its last step
  a_id_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    id_step_r <= bmc_pkg::ID_LAST)
    else $error("id step out of range");

  // a word leaving the input register always lands in the output register
  a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid_r)
    else $error("decoded word lost");

  // flash address is zero unless the word targets the flash
  a_flash_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r != bmc_pkg::TGT_FLASH_RD)
                  && (out_tuser_r != bmc_pkg::TGT_FLASH_WR)) |-> (out_tdata_r[22:0] == '0))
    else $error("flash address on non-flash target");

  // a word in the input register stays there while the output side is blocked
  a_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("pending word dropped during stall");

endmodule

/* tb/sv/bmc_route_sb_pkg.sv */
// routing scoreboard for the cartridge bank mapper testbench
// depends on bmc_pkg; predicts each routing word from the cpu words accepted
`timescale 1ns / 1ps

package bmc_route_sb_pkg;
  import bmc_pkg::*;

  typedef struct {
    target_t           target;
    logic [FlashW-1:0] flash_addr;
    logic [ByteW-1:0]  read_data;
    logic [ByteW-1:0]  sound_offset;
    logic              plus_mode;
    logic [GenRegW-1:0] gen_reg;
    logic [ByteW-1:0]  write_value;
  } route_t;

  class bank_route_scoreboard;
    // mapper state as the predictor sees it
    logic [BankW-1:0]   bank_adj [NumBanks];
    logic [ByteW-1:0]   bank_raw [NumBanks];
    logic [ByteW-1:0]   enable_bits;
    logic [ByteW-1:0]   offset_value;
    logic [ByteW-1:0]   mode_bits;
    logic [IdStepW-1:0] id_step;
    logic [ByteW-1:0]   sound_mode;
    logic [GenRegW-1:0] gen_latch;
    logic [ByteW-1:0]   id_answer [5] = '{8'hFF, 8'h1F, 8'h23, 8'h00, 8'h00};

    route_t pending_routes[$];
    int     errors;
    int     words_checked;
    int     per_target [8];

    function new();
      for (int i = 0; i < NumBanks; i++) begin
        bank_adj[i] = BankW'(i);
        bank_raw[i] = ByteW'(i);
      end
      enable_bits  = '0;
      offset_value = '0;
      mode_bits    = '0;
      id_step      = '0;
      sound_mode   = '0;
      gen_latch    = '0;
      errors       = 0;
      words_checked = 0;
    endfunction

    function int pending();
      return pending_routes.size();
    endfunction

    // outside 0x4000..0xbfff the cpu sees the mirror with bit 15 flipped
    function logic [AddrW-1:0] mirror(input logic [AddrW-1:0] a);
      if (a < 16'h4000 || a >= 16'hC000) begin
        return a ^ 16'h8000;
      end
      return a;
    endfunction

    function logic sound_hit(input logic [AddrW-1:0] a);
      if (mode_bits[3]) begin
        return 1'b0;
      end
      if (sound_mode[5]) begin
        return bank_raw[3][7] && a >= 16'hB800 && a < 16'hBFFE;
      end
      return bank_raw[2][5:0] == 6'h3F && a >= 16'h9800 && a < 16'hA000;
    endfunction

    function int page_of(input logic [AddrW-1:0] a);
      return (int'(a[15:13]) - 2) & 3;
    endfunction

    function logic [FlashW-1:0] flash_of(input logic [AddrW-1:0] a);
      return {bank_adj[page_of(a)], a[12:0]};
    endfunction

    function void switch_bank(input int page, input logic [ByteW-1:0] v);
      logic [BankW-1:0] off;
      off = {offset_value, mode_bits[5:4]};
      bank_adj[page] = BankW'(v + off);
      bank_raw[page] = v;
    endfunction

    // works out the routing word of one accepted cpu word
    function void route_access(input action_t act, input logic [AddrW-1:0] addr,
                               input logic [ByteW-1:0] data);
      route_t           r;
      logic [AddrW-1:0] a;
      logic [ByteW-1:0] port;
      logic             hit;
      r.target       = TGT_NONE;
      r.flash_addr   = '0;
      r.read_data    = '0;
      r.sound_offset = '0;
      r.gen_reg      = '0;
      r.write_value  = '0;
      case (act)
        ACT_MEM_RD: begin
          if (addr >= REG_ID && addr <= REG_ENABLE && enable_bits[0]) begin
            r.target = TGT_REG_RD;
            if (addr == REG_ID) begin
              r.read_data = (mode_bits[6] && id_step <= ID_LAST) ? id_answer[id_step] : 8'hFF;
            end else if (addr == REG_CONFIG) begin
              r.read_data = mode_bits | 8'h80;
            end else if (addr == REG_OFFSET) begin
              r.read_data = offset_value;
            end else begin
              r.read_data = enable_bits;
            end
          end else begin
            a = mirror(addr);
            if (sound_hit(a)) begin
              r.target       = TGT_SOUND_RD;
              r.sound_offset = a[7:0];
            end else if (!mode_bits[2]) begin
              r.target     = TGT_FLASH_RD;
              r.flash_addr = flash_of(a);
            end else begin
              r.target    = TGT_UNMAPPED;
              r.read_data = 8'hFF;
            end
          end
        end
        ACT_MEM_WR: begin
          // register writes land first, then the word takes the normal write path
          if (addr >= REG_ID && addr <= REG_ENABLE) begin
            if (addr == REG_ENABLE) begin
              enable_bits = data;
            end else if (enable_bits[0]) begin
              if (addr == REG_ID) begin
                if (mode_bits[6]) begin
                  if (id_step == 0) begin
                    if (data == ID_UNLOCK) id_step = 1;
                  end else if (id_step < ID_LAST) begin
                    id_step = id_step + 1;
                  end else begin
                    id_step = 0;
                  end
                end
              end else if (addr == REG_CONFIG) begin
                mode_bits = data;
              end else begin
                offset_value = data;
              end
            end
          end
          a = mirror(addr);
          if (enable_bits[4]) begin
            if (!mode_bits[2]) begin
              r.target      = TGT_FLASH_WR;
              r.flash_addr  = flash_of(a);
              r.write_value = data;
            end
          end else if (mode_bits[3]) begin
            if (!mode_bits[0] && a >= 16'h6000) switch_bank(page_of(a), data);
          end else begin
            if (sound_hit(a)) begin
              r.target       = TGT_SOUND_WR;
              r.sound_offset = a[7:0];
              r.write_value  = data;
            end
            if ((a & 16'h1800) == 16'h1000 && !mode_bits[0]) switch_bank(page_of(a), data);
            if (a[15:1] == 15'h5FFF) sound_mode = data;
          end
        end
        ACT_IO_WR: begin
          port = addr[7:0];
          hit  = port == PORT_GEN_LATCH || port == PORT_GEN_DATA ||
                 ((port == PORT_ECHO_LATCH || port == PORT_ECHO_DATA) && mode_bits[1]);
          if (hit) begin
            if (port[0]) begin
              r.target      = TGT_GEN_WR;
              r.gen_reg     = gen_latch;
              r.write_value = data;
            end else begin
              gen_latch = data[3:0];
            end
          end
        end
        default: ;
      endcase
      r.plus_mode = sound_mode[5];
      pending_routes.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    // checks one accepted routing word against the oldest prediction
    function void check_route(input target_t tgt, input logic [OutDataW-1:0] w);
      route_t r;
      if (pending_routes.size() == 0) begin
        errors++;
        $error("routing word with no cpu word pending: target %0d", tgt);
        return;
      end
      r = pending_routes.pop_front();
      words_checked++;
      per_target[r.target]++;
      compare_field("target",          r.target,       tgt);
      compare_field("flash_addr",      r.flash_addr,   w[22:0]);
      compare_field("read_data",       r.read_data,    w[30:23]);
      compare_field("sound_offset",    r.sound_offset, w[38:31]);
      compare_field("sound_plus_mode", r.plus_mode,    w[39]);
      compare_field("gen_reg",         r.gen_reg,      w[43:40]);
      compare_field("write_value",     r.write_value,  w[51:44]);
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
// top testbench of the cartridge bank mapper: directed and random cpu words
// depends on bmc_pkg, bmc_route_sb_pkg and bank_mapper_cartridge
`timescale 1ns / 1ps

module tb;
  import bmc_pkg::*;
  import bmc_route_sb_pkg::*;

  localparam int RandomWords = 1650;
  localparam int HoldCycles  = 300;     // long receiver hold-off, fills the pipe
  localparam int CycleLimit  = 500000;  // far above the slowest correct run

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;   // address[15:0], data[23:16]
  logic [ActionW-1:0]  in_tuser   = '0;   // action[1:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // flash_addr[22:0], read_data[30:23], sound_offset[38:31],
  // sound_plus_mode[39], gen_reg[43:40], write_value[51:44], zero[55:52]
  logic [OutDataW-1:0] out_tdata;
  logic [TargetW-1:0]  out_tuser;         // target[2:0]

  bank_route_scoreboard sb = new();

  int   words_sent   = 0;
  int   cycles       = 0;
  logic in_gaps_on   = 1'b1;
  logic out_stalls_on = 1'b1;
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;

  bank_mapper_cartridge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // offers one cpu word after a random gap and waits until it is taken;
  // valid stays high when the next word follows without a gap
  task automatic send_word(input action_t act, input logic [AddrW-1:0] addr,
                           input logic [ByteW-1:0] data);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
    sb.route_access(act, addr, data);
    words_sent++;
  endtask

  // register setup: enable first, since the others need enable bit 0
  task automatic setup_registers();
    logic [ByteW-1:0] en;
    logic [ByteW-1:0] md;
    logic [ByteW-1:0] off;
    en    = ByteW'($urandom);
    en[0] = $urandom_range(0, 7) != 0;
    en[4] = $urandom_range(0, 5) == 0;
    md    = ByteW'($urandom);
    md[0] = $urandom_range(0, 4) == 0;
    md[2] = $urandom_range(0, 4) == 0;
    md[3] = $urandom_range(0, 2) == 0;
    off   = ByteW'($urandom);
    case ($urandom_range(0, 5))
      0: off = 8'h00;
      1: off = 8'hFF;
      2: md  = 8'h00;   // plain sound-chip scheme, flash on, id and echo ports off
      default: ;
    endcase
    send_word(ACT_MEM_WR, REG_ENABLE, en);
    send_word(ACT_MEM_WR, REG_CONFIG, md);
    send_word(ACT_MEM_WR, REG_OFFSET, off);
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < 4; k++) send_word(ACT_MEM_RD, REG_ID + AddrW'(k), 8'h00);
    end
  endtask

  // cpu address biased toward windows, switch areas and the register block
  function automatic logic [AddrW-1:0] pick_address();
    logic [AddrW-1:0] a;
    case ($urandom_range(0, 6))
      0: a = 16'h9800 + AddrW'($urandom_range(0, 16'h7FF));
      1: a = 16'hB800 + AddrW'($urandom_range(0, 16'h7FF));
      2: a = REG_ID + AddrW'($urandom_range(0, 3));
      3: a = 16'h4000 + AddrW'($urandom_range(0, 3)) * 16'h2000 + 16'h1000
             + AddrW'($urandom_range(0, 16'h7FF));
      default: a = AddrW'($urandom);
    endcase
    // mirrored view of the same location, but never of the register block
    if (a[14:2] != 13'h1FFF && $urandom_range(0, 2) == 0) a = a ^ 16'h8000;
    return a;
  endfunction

  task automatic run_scenario();
    logic [ByteW-1:0] d;
    logic [AddrW-1:0] a;
    logic [ByteW-1:0] port;
    int               n;
    case ($urandom_range(0, 11))
      0: setup_registers();
      1, 2: begin
        // bank switching followed by reads through the new banks
        n = $urandom_range(1, 4);
        repeat (n) begin
          a = 16'h4000 + AddrW'($urandom_range(0, 3)) * 16'h2000 + 16'h1000
              + AddrW'($urandom_range(0, 16'h7FF));
          if ($urandom_range(0, 4) == 0) a[12:0] = 13'($urandom);
          if ($urandom_range(0, 3) == 0) a = a ^ 16'h8000;
          d = ByteW'($urandom);
          case ($urandom_range(0, 2))
            0: d[5:0] = 6'h3F;
            1: d[7]   = 1'b1;
            default: ;
          endcase
          send_word(ACT_MEM_WR, a, d);
        end
        n = $urandom_range(1, 4);
        repeat (n) send_word(ACT_MEM_RD, pick_address(), ByteW'($urandom));
      end
      3, 4, 5: begin
        n = $urandom_range(2, 8);
        repeat (n) send_word(ACT_MEM_RD, pick_address(), ByteW'($urandom));
      end
      6: begin
        n = $urandom_range(1, 5);
        repeat (n) send_word(ACT_MEM_WR, pick_address(), ByteW'($urandom));
      end
      7: begin
        // sound-chip mode register, direct or mirrored
        a = 16'hBFFE | AddrW'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) a = a ^ 16'h8000;
        send_word(ACT_MEM_WR, a, ByteW'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) send_word(ACT_MEM_RD, pick_address(), 8'h00);
      end
      8, 9: begin
        // generator latch then data writes, junk in the upper port byte
        case ($urandom_range(0, 3))
          0, 1: port = PORT_GEN_LATCH;
          2:    port = PORT_ECHO_LATCH;
          default: port = ByteW'($urandom) & 8'hFE;
        endcase
        send_word(ACT_IO_WR, {ByteW'($urandom), port}, ByteW'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) send_word(ACT_IO_WR, {ByteW'($urandom), port | 8'h01}, ByteW'($urandom));
      end
      10: begin
        // id reply sequence, usually unlocked
        if ($urandom_range(0, 1)) begin
          send_word(ACT_MEM_WR, REG_ENABLE, ByteW'($urandom) & 8'hEF | 8'h01);
          send_word(ACT_MEM_WR, REG_CONFIG, ByteW'($urandom) | 8'h40);
        end
        send_word(ACT_MEM_WR, REG_ID,
                  $urandom_range(0, 3) == 0 ? ByteW'($urandom) : ID_UNLOCK);
        repeat (6) begin
          send_word(ACT_MEM_RD, REG_ID, 8'h00);
          send_word(ACT_MEM_WR, REG_ID, ByteW'($urandom));
        end
      end
      default: begin
        // noise, any action including the unused one
        send_word(action_t'($urandom_range(0, 3)), AddrW'($urandom), ByteW'($urandom));
      end
    endcase
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) out_stalls_on = ~out_stalls_on;
        stall = out_stalls_on ? $urandom_range(0, 18) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_route(target_t'(out_tuser), out_tdata);
    end
  end

  // stimulus and end of run
  initial begin
    int directed_words;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, state carries from one word to the next
    send_word(ACT_MEM_RD, 16'h0000, 8'h00);     // low mirror
    send_word(ACT_MEM_RD, 16'hFFFF, 8'hFF);     // high mirror, all ones
    send_word(ACT_MEM_RD, 16'h4000, 8'h00);
    send_word(ACT_IO_WR,  16'h0010, 8'hFF);     // latch generator register
    send_word(ACT_IO_WR,  16'h0011, 8'hA5);     // generator write
    send_word(ACT_IO_WR,  16'h00A1, 8'h5A);     // echo port while disabled
    send_word(ACT_NOP,    16'hFFFF, 8'hFF);
    send_word(ACT_MEM_RD, REG_CONFIG, 8'h00);   // register block disabled
    send_word(ACT_MEM_WR, REG_ENABLE, 8'h01);
    send_word(ACT_MEM_RD, REG_ID, 8'h00);       // id channel off
    send_word(ACT_MEM_WR, REG_CONFIG, 8'h42);   // id channel, echo ports
    send_word(ACT_MEM_RD, REG_CONFIG, 8'h00);
    send_word(ACT_MEM_WR, REG_ID, ID_UNLOCK);
    send_word(ACT_MEM_RD, REG_ID, 8'h00);
    send_word(ACT_MEM_WR, REG_OFFSET, 8'hFF);   // largest offset, banks wrap
    send_word(ACT_MEM_WR, 16'h9000, 8'h3F);     // opens the sound window
    send_word(ACT_MEM_RD, 16'h9800, 8'h00);
    send_word(ACT_MEM_WR, 16'h98FF, 8'h77);
    send_word(ACT_MEM_WR, 16'hBFFE, 8'h20);     // plus mode
    send_word(ACT_MEM_WR, 16'hB7FF, 8'h80);
    send_word(ACT_MEM_RD, 16'hB800, 8'h00);
    send_word(ACT_IO_WR,  16'h12A0, 8'h03);     // echo latch, now enabled
    send_word(ACT_MEM_WR, REG_CONFIG, 8'h0C);   // four-bank scheme, flash off
    send_word(ACT_MEM_RD, 16'h6000, 8'h00);     // unmapped read
    send_word(ACT_MEM_WR, REG_ENABLE, 8'h11);   // flash write while flash off
    send_word(ACT_MEM_WR, REG_CONFIG, 8'h08);   // flash back on, flash write
    directed_words = words_sent;

    while (words_sent < directed_words + RandomWords) begin
      if ($urandom_range(0, 14) == 0) in_gaps_on = ~in_gaps_on;
      if (!hold_done && words_sent >= directed_words + RandomWords / 2) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
      end
      run_scenario();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d cpu words: %0d flash reads, %0d flash writes, %0d sound reads,",
             words_sent, sb.per_target[TGT_FLASH_RD], sb.per_target[TGT_FLASH_WR],
             sb.per_target[TGT_SOUND_RD]);
    $display("  %0d sound writes, %0d register reads, %0d generator writes, %0d unmapped",
             sb.per_target[TGT_SOUND_WR], sb.per_target[TGT_REG_RD],
             sb.per_target[TGT_GEN_WR], sb.per_target[TGT_UNMAPPED]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bmc_pkg.sv
sv/bank_mapper_cartridge.sv
tb/sv/bmc_route_sb_pkg.sv
tb/sv/tb.sv
